>>> hdl/assert_macros.svh
// Assertion macros for the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, clocked and disabled during reset
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Same-cycle implication
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication failed");

// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

>>> hdl/trsd_pkg.sv
package trsd_pkg;

  localparam int RECORD_BYTES = 16;
  localparam int WINDOW_BYTES = 2 * RECORD_BYTES;
  localparam int CNT_W        = $clog2(WINDOW_BYTES + 1);

  localparam int FREQ_W = 32;
  localparam int MODE_W = 4;
  localparam int BW_W   = 5;
  localparam int TDATA_W = 48;

  localparam logic [BW_W-1:0] BW_MAX = 5'd24;

  // Record byte offsets
  localparam int OFS_FREQ = 1;
  localparam int OFS_MODE = 7;
  localparam int OFS_FILT = 8;

  // Raw bytes of one record that the decoder needs
  typedef struct packed {
    logic [FREQ_W-1:0] freq_raw;
    logic [7:0]        mode_byte;
    logic [7:0]        filt_byte;
  } rec_raw_t;

  typedef struct packed {
    logic [FREQ_W-1:0] freq_hz;
    logic [MODE_W-1:0] mode_index;
    logic [BW_W-1:0]   bandwidth_index;
  } rec_t;

  // Closing byte seen; full when the reply held two whole records
  typedef struct packed {
    logic valid;
    logic full;
  } evt_t;

  function automatic logic [MODE_W-1:0] base_mode(input logic [2:0] code);
    logic [MODE_W-1:0] m;
    unique case (code)
      3'd0:    m = 4'd0;
      3'd1:    m = 4'd1;
      3'd2:    m = 4'd2;
      3'd3:    m = 4'd4;
      3'd4:    m = 4'd6;
      3'd5:    m = 4'd7;
      3'd6:    m = 4'd9;
      default: m = 4'd0;
    endcase
    return m;
  endfunction

endpackage

>>> hdl/trsd_window.sv
module trsd_window (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [7:0]                  rx_byte,
  input  logic                        end_of_reply,
  input  logic                        take,
  output logic [7:0]                  win [trsd_pkg::WINDOW_BYTES],
  output trsd_pkg::evt_t              evt
);

  logic [trsd_pkg::CNT_W-1:0] bytes_seen;
  logic [trsd_pkg::CNT_W-1:0] bytes_seen_next;

  always_comb begin
    if (bytes_seen == trsd_pkg::CNT_W'(trsd_pkg::WINDOW_BYTES)) begin
      bytes_seen_next = bytes_seen;
    end else begin
      bytes_seen_next = bytes_seen + 1'b1;
    end
  end

  // oldest byte at index 0
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < trsd_pkg::WINDOW_BYTES - 1; i++) begin
        win[i] <= win[i+1];
      end
      win[trsd_pkg::WINDOW_BYTES-1] <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen <= '0;
      evt        <= '0;
    end else begin
      if (accept) begin
        bytes_seen <= end_of_reply ? '0 : bytes_seen_next;
      end
      if (accept && end_of_reply) begin
        evt.valid <= 1'b1;
        evt.full  <= (bytes_seen_next == trsd_pkg::CNT_W'(trsd_pkg::WINDOW_BYTES));
      end else if (take) begin
        evt.valid <= 1'b0;
      end
    end
  end

endmodule

>>> hdl/trsd_decode.sv
module trsd_decode (
  input  trsd_pkg::rec_raw_t raw,
  output trsd_pkg::rec_t     rec
);

  logic [trsd_pkg::FREQ_W+3:0] prod;
  logic [5:0]                  bw_sum;

  // x10 as x8 + x2
  assign prod = {1'b0, raw.freq_raw, 3'b000} + {3'b000, raw.freq_raw, 1'b0};

  assign bw_sum = 6'({raw.filt_byte[6:4], 2'b00}) + 6'(raw.filt_byte[6:4])
                + 6'(raw.filt_byte[2:0]);

  always_comb begin
    rec.freq_hz    = prod[trsd_pkg::FREQ_W+3:4];
    rec.mode_index = trsd_pkg::base_mode(raw.mode_byte[2:0])
                   + trsd_pkg::MODE_W'(raw.filt_byte[7]);
    if (bw_sum > 6'(trsd_pkg::BW_MAX)) begin
      rec.bandwidth_index = trsd_pkg::BW_MAX;
    end else begin
      rec.bandwidth_index = bw_sum[trsd_pkg::BW_W-1:0];
    end
  end

endmodule

>>> hdl/transceiver_status_record_decoder.sv
// Status reply decoder. Takes one reply byte per cycle on the slave side; tlast marks the
// closing byte. The last 32 bytes are kept in a shift register. When a reply of 32 bytes
// or more closes, two result items follow on the master side, VFO A (tuser 0) then VFO B
// (tuser 1, tlast 1); a shorter reply gives one item with frame_ok 0 and tlast 1. The
// closing byte sets a registered event in the window; the decoded results are then loaded
// into the output register that drives the master side. Throughput is one byte per cycle;
// the slave side stalls only when a closed reply is waiting because the output register
// still holds the previous reply's results.
module transceiver_status_record_decoder (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [7:0] rx_byte
  input  logic                          s_axis_tlast,  // end_of_reply
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [31:0] freq_hz, [35:32] mode_index, [40:36] bandwidth_index, [41] frame_ok
  output logic [trsd_pkg::TDATA_W-1:0]  m_axis_tdata,
  output logic                          m_axis_tuser,  // vfo_is_b
  output logic                          m_axis_tlast   // last
);

  localparam int RB = trsd_pkg::RECORD_BYTES;

  logic [7:0]         win [trsd_pkg::WINDOW_BYTES];
  trsd_pkg::evt_t     evt;
  trsd_pkg::rec_raw_t raw_a, raw_b;
  trsd_pkg::rec_t     dec_a, dec_b;
  trsd_pkg::rec_t     rec_a, rec_b, cur;

  logic accept, out_fire, pair_load, pair_last;
  logic pair_valid, pair_full, phase;

  assign accept = s_axis_tvalid && s_axis_tready;

  trsd_window u_window (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .rx_byte      (s_axis_tdata),
    .end_of_reply (s_axis_tlast),
    .take         (pair_load),
    .win          (win),
    .evt          (evt)
  );

  always_comb begin
    raw_a.freq_raw  = {win[trsd_pkg::OFS_FREQ],   win[trsd_pkg::OFS_FREQ+1],
                       win[trsd_pkg::OFS_FREQ+2], win[trsd_pkg::OFS_FREQ+3]};
    raw_a.mode_byte = win[trsd_pkg::OFS_MODE];
    raw_a.filt_byte = win[trsd_pkg::OFS_FILT];
    raw_b.freq_raw  = {win[RB+trsd_pkg::OFS_FREQ],   win[RB+trsd_pkg::OFS_FREQ+1],
                       win[RB+trsd_pkg::OFS_FREQ+2], win[RB+trsd_pkg::OFS_FREQ+3]};
    raw_b.mode_byte = win[RB+trsd_pkg::OFS_MODE];
    raw_b.filt_byte = win[RB+trsd_pkg::OFS_FILT];
  end

  trsd_decode u_dec_a (.raw(raw_a), .rec(dec_a));
  trsd_decode u_dec_b (.raw(raw_b), .rec(dec_b));

  // a short reply has a single item
  assign pair_last = !pair_full || phase;
  assign out_fire  = pair_valid && m_axis_tready;
  assign pair_load = evt.valid && (!pair_valid || (out_fire && pair_last));

  // window must not move while a closed reply waits to be decoded
  assign s_axis_tready = !evt.valid || pair_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_valid <= 1'b0;
      pair_full  <= 1'b0;
      phase      <= 1'b0;
    end else if (pair_load) begin
      pair_valid <= 1'b1;
      pair_full  <= evt.full;
      phase      <= 1'b0;
      rec_a      <= dec_a;
      rec_b      <= dec_b;
    end else if (out_fire) begin
      if (pair_last) begin
        pair_valid <= 1'b0;
        phase      <= 1'b0;
      end else begin
        phase <= 1'b1;
      end
    end
  end

  always_comb begin
    if (!pair_full) begin
      cur = '0;
    end else if (phase) begin
      cur = rec_b;
    end else begin
      cur = rec_a;
    end
  end

  assign m_axis_tvalid = pair_valid;
  assign m_axis_tdata  = {6'b000000, pair_full, cur.bandwidth_index, cur.mode_index,
                          cur.freq_hz};
  assign m_axis_tuser  = pair_full && phase;
  assign m_axis_tlast  = pair_last;

endmodule

>>> hdl/trsd_checker.sv
`include "assert_macros.svh"

module trsd_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic [7:0]                   s_axis_tdata,
  input logic                         s_axis_tlast,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [trsd_pkg::TDATA_W-1:0] m_axis_tdata,
  input logic                         m_axis_tuser,
  input logic                         m_axis_tlast
);

  logic in_fire, out_fire;

  assign in_fire  = s_axis_tvalid && s_axis_tready && s_axis_tlast && (s_axis_tdata == s_axis_tdata);
  assign out_fire = m_axis_tvalid && m_axis_tready;

  // stalled item holds
  `ASSERT_NEXT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready,
               m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
               && $stable(m_axis_tlast))

  // failed reply: single item, all fields zero
  `ASSERT_IMPL(a_short, clk, rst, m_axis_tvalid && !m_axis_tdata[41],
               m_axis_tlast && !m_axis_tuser && (m_axis_tdata[40:0] == 41'd0))

  // in a good reply only the B record closes it
  `ASSERT_IMPL(a_last_b, clk, rst, m_axis_tvalid && m_axis_tdata[41],
               m_axis_tlast == m_axis_tuser)

  // A is always followed straight away by B
  `ASSERT_NEXT(a_a_then_b, clk, rst, out_fire && m_axis_tdata[41] && !m_axis_tuser,
               m_axis_tvalid && m_axis_tuser && m_axis_tdata[41])

  // decoded indexes stay in range
  `ASSERT_IMPL(a_range, clk, rst, m_axis_tvalid || in_fire,
               !m_axis_tvalid || ((m_axis_tdata[35:32] <= 4'd10)
               && (m_axis_tdata[40:36] <= 5'd24)))

endmodule

bind transceiver_status_record_decoder trsd_checker u_trsd_checker (.*);

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import trsd_pkg::*;

  localparam int CYCLE_LIMIT  = 250000;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 20;
  localparam int RANDOM_BYTES = 1600;
  // base mode per 3-bit code, code 0 in the lowest nibble
  localparam logic [31:0] MODE_MAP = {4'd0, 4'd9, 4'd7, 4'd6, 4'd4, 4'd2, 4'd1, 4'd0};

  typedef struct packed {
    logic              vfo_is_b;
    logic [FREQ_W-1:0] freq_hz;
    logic [MODE_W-1:0] mode_index;
    logic [BW_W-1:0]   bandwidth_index;
    logic              frame_ok;
    logic              is_last;
  } vfo_status_t;

  class status_scoreboard;
    logic [7:0]    window [WINDOW_BYTES];
    int unsigned   reply_len;
    vfo_status_t   status_q[$];
    int unsigned   errors;

    function new();
      reply_len = 0;
      errors    = 0;
    endfunction

    function int pending();
      return status_q.size();
    endfunction

    task report(input string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    function vfo_status_t decode_vfo(input int base, input logic vfo);
      vfo_status_t r;
      logic [63:0] raw;
      logic [63:0] scaled;
      logic [7:0]  mode_b;
      logic [7:0]  filt_b;
      int          bw;
      raw    = {32'd0, window[base+1], window[base+2], window[base+3], window[base+4]};
      scaled = (raw * 64'd10) >> 4;
      mode_b = window[base+7];
      filt_b = window[base+8];
      bw     = 5 * int'(filt_b[6:4]) + int'(filt_b[2:0]);
      if (bw > 24)
        bw = 24;
      r.vfo_is_b        = vfo;
      r.freq_hz         = scaled[31:0];
      r.mode_index      = MODE_MAP[mode_b[2:0]*4 +: 4] + {3'd0, filt_b[7]};
      r.bandwidth_index = bw[BW_W-1:0];
      r.frame_ok        = 1'b1;
      r.is_last         = vfo;
      return r;
    endfunction

    task note_byte(input logic [7:0] b, input logic closing);
      vfo_status_t r;
      for (int i = 0; i < WINDOW_BYTES - 1; i++)
        window[i] = window[i+1];
      window[WINDOW_BYTES-1] = b;
      if (reply_len < WINDOW_BYTES)
        reply_len++;
      if (closing) begin
        if (reply_len >= WINDOW_BYTES) begin
          status_q.push_back(decode_vfo(0, 1'b0));
          status_q.push_back(decode_vfo(RECORD_BYTES, 1'b1));
        end else begin
          r = '0;
          r.is_last = 1'b1;
          status_q.push_back(r);
        end
        reply_len = 0;
      end
    endtask

    task check_result(input logic [TDATA_W-1:0] d, input logic vfo, input logic lst);
      vfo_status_t e;
      if (status_q.size() == 0) begin
        report($sformatf("unexpected item tdata=%h tuser=%b tlast=%b", d, vfo, lst));
        return;
      end
      e = status_q.pop_front();
      if (vfo !== e.vfo_is_b)
        report($sformatf("vfo_is_b %b, want %b", vfo, e.vfo_is_b));
      if (d[31:0] !== e.freq_hz)
        report($sformatf("freq_hz %0d, want %0d", d[31:0], e.freq_hz));
      if (d[35:32] !== e.mode_index)
        report($sformatf("mode_index %0d, want %0d", d[35:32], e.mode_index));
      if (d[40:36] !== e.bandwidth_index)
        report($sformatf("bandwidth_index %0d, want %0d", d[40:36], e.bandwidth_index));
      if (d[41] !== e.frame_ok)
        report($sformatf("frame_ok %b, want %b", d[41], e.frame_ok));
      if (d[TDATA_W-1:42] !== '0)
        report($sformatf("padding bits %h not zero", d[TDATA_W-1:42]));
      if (lst !== e.is_last)
        report($sformatf("tlast %b, want %b", lst, e.is_last));
    endtask
  endclass

  logic               clk;
  logic               rst;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [7:0]         s_axis_tdata;
  logic               s_axis_tlast;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [TDATA_W-1:0] m_axis_tdata;
  logic               m_axis_tuser;
  logic               m_axis_tlast;

  transceiver_status_record_decoder dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  status_scoreboard sb;
  logic [7:0]       reply[$];
  bit               steady;    // no random idling on either side while set
  bit               hold_req;
  int               hold_left;
  int               cycles;
  int               bytes_sent;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result side: check, then decide next tready
  initial begin
    m_axis_tready <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else if (rst) begin
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 23);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic closing);
    while (!steady && $urandom_range(0, 99) < 23) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= closing;
    @(posedge clk);
    while (!s_axis_tready)
      @(posedge clk);
    sb.note_byte(b, closing);
    bytes_sent++;
  endtask

  task automatic send_reply();
    for (int i = 0; i < reply.size(); i++)
      send_byte(reply[i], i == reply.size() - 1);
  endtask

  task automatic fill_random(input int n);
    reply.delete();
    repeat (n) reply.push_back(8'($urandom));
  endtask

  // place the bytes of one record that the decoder reads among the last two records of the reply
  task automatic put_vfo(input int vfo, input logic [31:0] raw, input logic [7:0] mode_b,
                         input logic [7:0] filt_b);
    int base;
    base = reply.size() - WINDOW_BYTES + vfo * RECORD_BYTES;
    reply[base+1] = raw[31:24];
    reply[base+2] = raw[23:16];
    reply[base+3] = raw[15:8];
    reply[base+4] = raw[7:0];
    reply[base+7] = mode_b;
    reply[base+8] = filt_b;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0)
      @(posedge clk);
  endtask

  initial begin
    int kind;
    int n_reply;
    sb = new();
    steady     = 1'b0;
    hold_req   = 1'b0;
    bytes_sent = 0;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'h00;
    s_axis_tlast  <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: frequency extremes, all mode codes, alternate bit, bandwidth saturation
    fill_random(WINDOW_BYTES);
    put_vfo(0, 32'hFFFF_FFFF, 8'h00, 8'h00);
    put_vfo(1, 32'h0000_0000, 8'h01, 8'hF7);
    send_reply();
    fill_random(WINDOW_BYTES);
    put_vfo(0, 32'h8000_0001, 8'hFA, 8'h44);
    put_vfo(1, 32'h0000_0001, 8'h03, 8'h43);
    send_reply();
    fill_random(WINDOW_BYTES + 8);   // long reply: only the tail counts
    put_vfo(0, 32'h1234_5678, 8'h04, 8'h80);
    put_vfo(1, 32'h7FFF_FFFF, 8'h05, 8'hFF);
    send_reply();
    fill_random(WINDOW_BYTES + 1);
    put_vfo(0, 32'hDEAD_BEEF, 8'h06, 8'h07);
    put_vfo(1, 32'h0F0F_0F0F, 8'hFF, 8'h70);
    send_reply();
    fill_random(1);                  // closing byte alone
    send_reply();
    fill_random(WINDOW_BYTES - 1);   // one byte short
    send_reply();
    drain();

    n_reply = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      steady = (n_reply >= 10 && n_reply < 20) || (n_reply >= 25 && n_reply < 30);
      if (n_reply == 25)
        hold_req = 1'b1;
      if (n_reply == 35)
        drain();
      kind = $urandom_range(0, 99);
      if (kind < 70)
        fill_random(WINDOW_BYTES + $urandom_range(0, 8));
      else if (kind < 85)
        fill_random($urandom_range(1, WINDOW_BYTES - 1));
      else
        fill_random($urandom_range(1, 70));
      send_reply();
      n_reply++;
    end
    steady = 1'b0;

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
